### rtl/core/assembler_line_token_tagger_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the assembler line token tagger
// Concurrent checks clocked on clk_i and disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef ASSEMBLER_LINE_TOKEN_TAGGER_MACROS_SVH
`define ASSEMBLER_LINE_TOKEN_TAGGER_MACROS_SVH

// A property that must hold at every rising clock edge.
`define TAG_CHECK(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("line token tagger: invariant violated");

// A condition that must hold in the cycle after a trigger.
`define TAG_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("line token tagger: next-cycle check failed");

`endif

### rtl/core/altt_pkg.sv
// ----------------------------------------------------------------------------
// Assembler line token tagger package
// Word types, phase and record codes, character constants and keyword matchers.
// ----------------------------------------------------------------------------
package altt_pkg;

  localparam int unsigned LINE_LENGTH_MAX_DEF = 1024;
  localparam int unsigned MAX_RESULTS         = 3;
  localparam int unsigned FIFO_DEPTH          = 4;

  // Line phases.
  localparam logic [2:0] PH_START   = 3'd0;
  localparam logic [2:0] PH_LABEL   = 3'd1;
  localparam logic [2:0] PH_OPCODE  = 3'd2;
  localparam logic [2:0] PH_ARG     = 3'd3;
  localparam logic [2:0] PH_COMMENT = 3'd4;

  // Record kinds.
  localparam logic [2:0] KIND_LABEL   = 3'd0;
  localparam logic [2:0] KIND_OPCODE  = 3'd1;
  localparam logic [2:0] KIND_ARG     = 3'd2;
  localparam logic [2:0] KIND_COMMENT = 3'd3;
  localparam logic [2:0] KIND_SUMMARY = 3'd4;

  // Keyword match progress.
  localparam logic [2:0] MATCH_FAIL = 3'd7;
  localparam logic [2:0] EQU_DONE   = 3'd3;
  localparam logic [2:0] DATA_DONE  = 3'd4;

  localparam logic [7:0] ARG_MAX        = 8'd255;
  localparam logic [7:0] ARG_WARN_LIMIT = 8'd2;

  // Characters.
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_UP_A   = 8'h41;
  localparam logic [7:0] CH_UP_Z   = 8'h5A;
  localparam logic [7:0] CASE_OFS  = 8'h20;
  localparam logic [7:0] CH_LO_A   = 8'h61;
  localparam logic [7:0] CH_LO_D   = 8'h64;
  localparam logic [7:0] CH_LO_E   = 8'h65;
  localparam logic [7:0] CH_LO_Q   = 8'h71;
  localparam logic [7:0] CH_LO_T   = 8'h74;
  localparam logic [7:0] CH_LO_U   = 8'h75;

  typedef struct packed {
    logic [7:0] ch;
    logic       has_char;
    logic       end_of_line;
  } in_t;

  typedef struct packed {
    logic [2:0]  record_kind;
    logic [7:0]  arg_index;
    logic [9:0]  token_start;
    logic [10:0] token_length;
    logic [7:0]  arg_total;
    logic        label_warning;
    logic        extra_text_warning;
    logic        line_too_long;
    logic        last;
  } out_t;

  function automatic logic [7:0] to_lower(logic [7:0] c);
    return (c >= CH_UP_A && c <= CH_UP_Z) ? c + CASE_OFS : c;
  endfunction

  function automatic logic [2:0] equ_step(logic [2:0] prog, logic [7:0] c);
    logic [7:0] lc;
    logic       hit;
    lc = to_lower(c);
    case (prog)
      3'd0:    hit = (lc == CH_LO_E);
      3'd1:    hit = (lc == CH_LO_Q);
      3'd2:    hit = (lc == CH_LO_U);
      default: hit = 1'b0;
    endcase
    return hit ? prog + 3'd1 : MATCH_FAIL;
  endfunction

  function automatic logic [2:0] data_step(logic [2:0] prog, logic [7:0] c);
    logic [7:0] lc;
    logic       hit;
    lc = to_lower(c);
    case (prog)
      3'd0:    hit = (lc == CH_LO_D);
      3'd1:    hit = (lc == CH_LO_A);
      3'd2:    hit = (lc == CH_LO_T);
      3'd3:    hit = (lc == CH_LO_A);
      default: hit = 1'b0;
    endcase
    return hit ? prog + 3'd1 : MATCH_FAIL;
  endfunction

endpackage

### rtl/core/assembler_line_token_tagger.sv
// ----------------------------------------------------------------------------
// Assembler line token tagger: splits a source line into label, opcode, args.
// The input word is registered; its results enter the result queue when it advances.
// Throughput: one word per cycle; the queue holds four result words and the
// input stalls while more than one would still wait after this cycle's pop.
// Reset clears the line state, the input valid flag and the result queue.
// ----------------------------------------------------------------------------
`include "assembler_line_token_tagger_macros.svh"

module assembler_line_token_tagger
  import altt_pkg::*;
#(
  parameter int unsigned LINE_LENGTH_MAX = LINE_LENGTH_MAX_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  in_t  in_word_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output out_t out_word_o
);

  localparam int unsigned PW   = $clog2(LINE_LENGTH_MAX + 1);
  localparam int unsigned OW   = $clog2(LINE_LENGTH_MAX);
  localparam int unsigned PTRW = $clog2(FIFO_DEPTH);
  localparam int unsigned CW   = $clog2(FIFO_DEPTH + 1);
  localparam logic [PW-1:0] PosMax = PW'(LINE_LENGTH_MAX);

  // Input register.
  logic in_vld_q;
  in_t  in_q;
  logic load, adv, room, pop;

  // Line state.
  logic [2:0]    phase_q, phase_d;
  logic          quote_q, quote_d, dquote_q, dquote_d;
  logic          esc_q, esc_d, skip_q, skip_d;
  logic [PW-1:0] pos_q, pos_d;
  logic [OW-1:0] start_q, start_d, lnb_q, lnb_d;
  logic          open_q, open_d, nbseen_q, nbseen_d;
  logic [7:0]    argc_q, argc_d, lfc_q, lfc_d;
  logic [2:0]    equ_q, equ_d, data_q, data_d;
  logic          dot_q, dot_d, ovf_q, ovf_d;

  // Results of the word in the input register.
  out_t       res [MAX_RESULTS];
  logic [1:0] res_n;

  // Result queue.
  out_t            fifo_q [FIFO_DEPTH];
  logic [PTRW-1:0] wr_q, rd_q;
  logic [CW-1:0]   cnt_q;

  function automatic out_t mk_rec(logic [2:0] kind, logic [7:0] idx, logic [OW-1:0] start,
                                  logic [PW-1:0] len, logic [7:0] cnt, logic lw,
                                  logic xw, logic lt);
    out_t r;
    r.record_kind        = kind;
    r.arg_index          = idx;
    r.token_start        = 10'(start);
    r.token_length       = 11'(len);
    r.arg_total          = cnt;
    r.label_warning      = lw;
    r.extra_text_warning = xw;
    r.line_too_long      = lt;
    r.last               = 1'b0;
    return r;
  endfunction

  assign pop         = out_valid_o && !out_stall_i;
  assign room        = (cnt_q - CW'(pop)) <= CW'(FIFO_DEPTH - MAX_RESULTS);
  assign adv         = in_vld_q && room;
  assign in_stall_o  = in_vld_q && !room;
  assign load        = in_valid_i && !in_stall_o;
  assign out_valid_o = (cnt_q != '0);
  assign out_word_o  = fifo_q[rd_q];

  always_comb begin
    logic [7:0]    c;
    logic          has, eol, blank;
    logic          do_open, do_ext, do_fin, do_com;
    logic [2:0]    ph_after;
    logic          open_after;
    logic [PW-1:0] len;
    c       = in_q.ch;
    has     = adv && in_q.has_char;
    eol     = adv && in_q.end_of_line;
    blank   = (c == CH_SPACE) || (c == CH_TAB);
    do_open = 1'b0;
    do_ext  = 1'b0;
    do_fin  = 1'b0;
    do_com  = 1'b0;
    len     = '0;

    phase_d  = phase_q;
    quote_d  = quote_q;
    dquote_d = dquote_q;
    esc_d    = esc_q;
    skip_d   = skip_q;
    pos_d    = pos_q;
    start_d  = start_q;
    lnb_d    = lnb_q;
    open_d   = open_q;
    nbseen_d = nbseen_q;
    argc_d   = argc_q;
    lfc_d    = lfc_q;
    equ_d    = equ_q;
    data_d   = data_q;
    dot_d    = dot_q;
    ovf_d    = ovf_q;

    res   = '{default: '0};
    res_n = '0;

    if (has) begin
      if (pos_q >= PosMax) begin
        ovf_d = 1'b1;
      end else begin
        pos_d = pos_q + 1'b1;
        if (skip_q) begin
          // The character right after a closing quote is dropped.
          skip_d = 1'b0;
        end else begin
          if (phase_q == PH_START) begin
            phase_d = (blank || c == CH_NUL) ? PH_OPCODE : PH_LABEL;
          end
          if (phase_q == PH_COMMENT) begin
            if (!blank) begin
              lnb_d = pos_q[OW-1:0];
            end
          end else if (phase_q == PH_START || !open_q) begin
            if (!blank) begin
              if (c == CH_SEMI) begin
                do_com = 1'b1;
              end else if (!(phase_q == PH_ARG && c == CH_COMMA)) begin
                do_open = 1'b1;
              end
            end
          end else if (quote_q) begin
            do_ext = 1'b1;
            if (esc_q) begin
              esc_d = 1'b0;
            end else if (c == CH_BSLASH) begin
              esc_d = 1'b1;
            end else if (c == (dquote_q ? CH_DQUOTE : CH_SQUOTE)) begin
              do_fin = 1'b1;
              skip_d = 1'b1;
            end
          end else if (c == CH_SEMI) begin
            do_fin = 1'b1;
            do_com = 1'b1;
          end else if (phase_q == PH_ARG ? (c == CH_COMMA) : blank) begin
            do_fin = 1'b1;
          end else begin
            do_ext = 1'b1;
          end
        end
      end
    end

    if (do_open) begin
      open_d   = 1'b1;
      nbseen_d = 1'b1;
      start_d  = pos_q[OW-1:0];
      quote_d  = (c == CH_SQUOTE) || (c == CH_DQUOTE);
      dquote_d = (c == CH_DQUOTE);
      esc_d    = 1'b0;
      if (phase_d == PH_OPCODE) begin
        dot_d = (c == CH_DOT);
      end
      do_ext = 1'b1;
    end

    if (do_ext) begin
      if (!blank) begin
        lnb_d = pos_q[OW-1:0];
      end
      if (phase_d == PH_LABEL) begin
        if (!blank) begin
          lfc_d = c;
        end
        equ_d = equ_step(equ_d, c);
      end else if (phase_d == PH_OPCODE) begin
        data_d = data_step(data_d, c);
      end
    end

    // At most one token closes per word: either on the character or at end of line.
    ph_after   = do_com ? PH_COMMENT : phase_d;
    open_after = do_com || (open_d && !do_fin);
    if (eol && !do_fin && open_after && ph_after >= PH_LABEL && ph_after <= PH_ARG) begin
      do_fin = 1'b1;
    end

    if (do_fin) begin
      len = PW'(lnb_d) - PW'(start_d) + PW'(1);
      if (phase_d == PH_LABEL) begin
        if (lfc_d == CH_COLON || lfc_d == CH_COMMA) begin
          len = len - PW'(1);
        end
        res[res_n] = mk_rec(KIND_LABEL, '0, start_d, len, '0, 1'b0, 1'b0, 1'b0);
        res_n      = res_n + 2'd1;
        phase_d    = PH_OPCODE;
      end else if (phase_d == PH_OPCODE) begin
        res[res_n] = mk_rec(KIND_OPCODE, '0, start_d, len, '0, 1'b0, 1'b0, 1'b0);
        res_n      = res_n + 2'd1;
        phase_d    = PH_ARG;
      end else if (phase_d == PH_ARG && nbseen_d) begin
        res[res_n] = mk_rec(KIND_ARG, argc_d, start_d, len, '0, 1'b0, 1'b0, 1'b0);
        res_n      = res_n + 2'd1;
        if (argc_d != ARG_MAX) begin
          argc_d = argc_d + 8'd1;
        end
      end
      open_d   = 1'b0;
      nbseen_d = 1'b0;
      quote_d  = 1'b0;
      esc_d    = 1'b0;
    end

    if (do_com) begin
      phase_d = PH_COMMENT;
      open_d  = 1'b1;
      start_d = pos_q[OW-1:0];
      lnb_d   = pos_q[OW-1:0];
    end

    if (eol) begin
      if (phase_d == PH_COMMENT) begin
        len        = PW'(lnb_d) - PW'(start_d) + PW'(1);
        res[res_n] = mk_rec(KIND_COMMENT, '0, start_d, len, '0, 1'b0, 1'b0, 1'b0);
        res_n      = res_n + 2'd1;
      end
      res[res_n] = mk_rec(KIND_SUMMARY, '0, '0, '0, argc_d, (equ_d == EQU_DONE),
                          (argc_d > ARG_WARN_LIMIT) && (data_d != DATA_DONE) && !dot_d,
                          ovf_d);
      res_n      = res_n + 2'd1;

      phase_d  = PH_START;
      quote_d  = 1'b0;
      dquote_d = 1'b0;
      esc_d    = 1'b0;
      skip_d   = 1'b0;
      pos_d    = '0;
      start_d  = '0;
      lnb_d    = '0;
      open_d   = 1'b0;
      nbseen_d = 1'b0;
      argc_d   = '0;
      lfc_d    = '0;
      equ_d    = '0;
      data_d   = '0;
      dot_d    = 1'b0;
      ovf_d    = 1'b0;
    end

    if (res_n != '0) begin
      res[res_n - 2'd1].last = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
      phase_q  <= PH_START;
      quote_q  <= 1'b0;
      dquote_q <= 1'b0;
      esc_q    <= 1'b0;
      skip_q   <= 1'b0;
      pos_q    <= '0;
      start_q  <= '0;
      lnb_q    <= '0;
      open_q   <= 1'b0;
      nbseen_q <= 1'b0;
      argc_q   <= '0;
      lfc_q    <= '0;
      equ_q    <= '0;
      data_q   <= '0;
      dot_q    <= 1'b0;
      ovf_q    <= 1'b0;
      wr_q     <= '0;
      rd_q     <= '0;
      cnt_q    <= '0;
    end else begin
      if (load) begin
        in_vld_q <= 1'b1;
      end else if (adv) begin
        in_vld_q <= 1'b0;
      end
      phase_q  <= phase_d;
      quote_q  <= quote_d;
      dquote_q <= dquote_d;
      esc_q    <= esc_d;
      skip_q   <= skip_d;
      pos_q    <= pos_d;
      start_q  <= start_d;
      lnb_q    <= lnb_d;
      open_q   <= open_d;
      nbseen_q <= nbseen_d;
      argc_q   <= argc_d;
      lfc_q    <= lfc_d;
      equ_q    <= equ_d;
      data_q   <= data_d;
      dot_q    <= dot_d;
      ovf_q    <= ovf_d;
      wr_q     <= wr_q + PTRW'(res_n);
      rd_q     <= rd_q + PTRW'(pop);
      cnt_q    <= cnt_q + CW'(res_n) - CW'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      in_q <= in_word_i;
    end
    for (int i = 0; i < MAX_RESULTS; i++) begin
      if (2'(i) < res_n) begin
        fifo_q[wr_q + PTRW'(i)] <= res[i];
      end
    end
  end

  `TAG_CHECK(a_queue_bound, cnt_q <= CW'(FIFO_DEPTH))
  `TAG_CHECK(a_pos_bound, pos_q <= PosMax)
  `TAG_NEXT(a_eol_clears_line, adv && in_q.end_of_line, phase_q == PH_START && pos_q == '0)
  `TAG_NEXT(a_skip_once, adv && skip_q && in_q.has_char && pos_q < PosMax, !skip_q)

endmodule

### test/assembler_line_token_tagger_check.sv
// ----------------------------------------------------------------------------
// Assembler line token tagger checker
// Watches both channels of the tagger. Every accepted input word goes through
// a line predictor that queues the records it should cause. Every accepted
// output word is compared with the oldest queued record. Hands the number of
// records still due and the number of failures to the testbench top.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module assembler_line_token_tagger_check
  import altt_pkg::*;
#(
  parameter int unsigned LINE_LENGTH_MAX = LINE_LENGTH_MAX_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  in_t         in_word_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  out_t        out_word_i,
  output int unsigned pending_o,
  output int unsigned errors_o
);

  // Line state of the predictor.
  logic [2:0]  phase_q;
  bit          in_str;
  bit          str_dq;
  bit          esc_q;
  bit          swallow_q;
  int unsigned col;
  int unsigned tok_begin;
  int unsigned tok_end;
  bit          tok_open;
  bit          tok_has_text;
  int unsigned args_seen;
  logic [7:0]  label_tail;
  logic [2:0]  equ_prog;
  logic [2:0]  data_prog;
  bit          op_dot;
  bit          too_long;

  out_t        records_due[$];
  out_t        word_records[$];
  int unsigned errors = 0;

  function automatic void clear_line();
    phase_q      = PH_START;
    in_str       = 1'b0;
    str_dq       = 1'b0;
    esc_q        = 1'b0;
    swallow_q    = 1'b0;
    col          = 0;
    tok_begin    = 0;
    tok_end      = 0;
    tok_open     = 1'b0;
    tok_has_text = 1'b0;
    args_seen    = 0;
    label_tail   = CH_NUL;
    equ_prog     = '0;
    data_prog    = '0;
    op_dot       = 1'b0;
    too_long     = 1'b0;
  endfunction

  function automatic bit is_blank(logic [7:0] c);
    return c == CH_SPACE || c == CH_TAB;
  endfunction

  // Case-insensitive keyword tracking; any miss sticks at MATCH_FAIL.
  function automatic logic [2:0] kw_step(logic [2:0] prog, logic [7:0] c, string kw);
    logic [7:0] lc;
    lc = (c >= CH_UP_A && c <= CH_UP_Z) ? c + CASE_OFS : c;
    if (prog < kw.len() && lc == 8'(kw[prog]))
      return prog + 3'd1;
    return MATCH_FAIL;
  endfunction

  function automatic void add_record(logic [2:0] kind, int unsigned idx, int unsigned start,
                                     int unsigned len, int unsigned cnt, bit lw, bit xw,
                                     bit lt);
    out_t r;
    r.record_kind        = kind;
    r.arg_index          = 8'(idx);
    r.token_start        = 10'(start);
    r.token_length       = 11'(len);
    r.arg_total          = 8'(cnt);
    r.label_warning      = lw;
    r.extra_text_warning = xw;
    r.line_too_long      = lt;
    r.last               = 1'b0;
    word_records.insert(word_records.size(), r);
  endfunction

  function automatic void grow_token(logic [7:0] c);
    if (!is_blank(c))
      tok_end = col;
    if (phase_q == PH_LABEL) begin
      if (!is_blank(c))
        label_tail = c;
      equ_prog = kw_step(equ_prog, c, "equ");
    end else if (phase_q == PH_OPCODE) begin
      data_prog = kw_step(data_prog, c, "data");
    end
  endfunction

  function automatic void open_tok(logic [7:0] c, bit quoted);
    tok_open     = 1'b1;
    tok_has_text = 1'b1;
    tok_begin    = col;
    in_str       = quoted;
    str_dq       = (c == CH_DQUOTE);
    esc_q        = 1'b0;
    if (phase_q == PH_OPCODE)
      op_dot = (c == CH_DOT);
    grow_token(c);
  endfunction

  function automatic void open_comment();
    phase_q   = PH_COMMENT;
    tok_open  = 1'b1;
    tok_begin = col;
    tok_end   = col;
  endfunction

  function automatic void close_tok();
    int unsigned len;
    len = tok_end - tok_begin + 1;
    if (phase_q == PH_LABEL) begin
      if (label_tail == CH_COLON || label_tail == CH_COMMA)
        len = len - 1;
      add_record(KIND_LABEL, 0, tok_begin, len, 0, 1'b0, 1'b0, 1'b0);
      phase_q = PH_OPCODE;
    end else if (phase_q == PH_OPCODE) begin
      add_record(KIND_OPCODE, 0, tok_begin, len, 0, 1'b0, 1'b0, 1'b0);
      phase_q = PH_ARG;
    end else if (phase_q == PH_ARG && tok_has_text) begin
      add_record(KIND_ARG, args_seen, tok_begin, len, 0, 1'b0, 1'b0, 1'b0);
      if (args_seen < ARG_MAX)
        args_seen++;
    end
    tok_open     = 1'b0;
    tok_has_text = 1'b0;
    in_str       = 1'b0;
    esc_q        = 1'b0;
  endfunction

  // Between tokens: blanks are skipped, a semicolon opens the comment and
  // separating commas between arguments open nothing.
  function automatic void seek_tok(logic [7:0] c);
    if (is_blank(c))
      return;
    if (c == CH_SEMI)
      open_comment();
    else if (phase_q == PH_ARG && c == CH_COMMA)
      return;
    else
      open_tok(c, c == CH_SQUOTE || c == CH_DQUOTE);
  endfunction

  function automatic void take_char(logic [7:0] c);
    if (swallow_q) begin
      swallow_q = 1'b0;
      return;
    end
    if (phase_q == PH_START) begin
      phase_q = (is_blank(c) || c == CH_NUL) ? PH_OPCODE : PH_LABEL;
      seek_tok(c);
    end else if (phase_q == PH_COMMENT) begin
      if (!is_blank(c))
        tok_end = col;
    end else if (phase_q <= PH_ARG) begin
      if (!tok_open) begin
        seek_tok(c);
      end else if (in_str) begin
        if (esc_q) begin
          esc_q = 1'b0;
          grow_token(c);
        end else if (c == CH_BSLASH) begin
          esc_q = 1'b1;
          grow_token(c);
        end else if (c == (str_dq ? CH_DQUOTE : CH_SQUOTE)) begin
          // The character right after a closing quote is dropped.
          grow_token(c);
          close_tok();
          swallow_q = 1'b1;
        end else begin
          grow_token(c);
        end
      end else if (c == CH_SEMI) begin
        close_tok();
        open_comment();
      end else if (phase_q == PH_ARG ? c == CH_COMMA : is_blank(c)) begin
        close_tok();
      end else begin
        grow_token(c);
      end
    end
  endfunction

  function automatic void tag_word(in_t w);
    word_records.delete();
    if (w.has_char) begin
      if (col >= LINE_LENGTH_MAX) begin
        too_long = 1'b1;
      end else begin
        take_char(w.ch);
        col++;
      end
    end
    if (w.end_of_line) begin
      if (phase_q == PH_COMMENT)
        add_record(KIND_COMMENT, 0, tok_begin, tok_end - tok_begin + 1, 0, 1'b0, 1'b0, 1'b0);
      else if (phase_q >= PH_LABEL && phase_q <= PH_ARG && tok_open)
        close_tok();
      add_record(KIND_SUMMARY, 0, 0, 0, args_seen, equ_prog == EQU_DONE,
                 args_seen > ARG_WARN_LIMIT && data_prog != DATA_DONE && !op_dot, too_long);
      clear_line();
    end
    if (word_records.size() > 0)
      word_records[$].last = 1'b1;
    foreach (word_records[i])
      records_due.insert(records_due.size(), word_records[i]);
  endfunction

  function automatic string show(out_t r);
    return $sformatf("kind %0d idx %0d start %0d len %0d cnt %0d lw %0b xw %0b lt %0b last %0b",
                     r.record_kind, r.arg_index, r.token_start, r.token_length, r.arg_total,
                     r.label_warning, r.extra_text_warning, r.line_too_long, r.last);
  endfunction

  function automatic void check_record(out_t got);
    out_t want;
    if (records_due.size() == 0) begin
      errors++;
      if (errors <= 10)
        $display("unexpected record: %s", show(got));
      return;
    end
    want = records_due.pop_front();
    if (got.record_kind !== want.record_kind || got.arg_index !== want.arg_index ||
        got.token_start !== want.token_start || got.token_length !== want.token_length ||
        got.arg_total !== want.arg_total || got.label_warning !== want.label_warning ||
        got.extra_text_warning !== want.extra_text_warning ||
        got.line_too_long !== want.line_too_long || got.last !== want.last) begin
      errors++;
      if (errors <= 10) begin
        $display("record mismatch at %0t", $realtime);
        $display("  expected %s", show(want));
        $display("  actual   %s", show(got));
      end
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_line();
      records_due.delete();
      pending_o <= 0;
    end else begin
      if (in_valid_i && !in_stall_i)
        tag_word(in_word_i);
      if (out_valid_i && !out_stall_i)
        check_record(out_word_i);
      pending_o <= records_due.size();
      errors_o  <= errors;
    end
  end

endmodule

### test/assembler_line_token_tagger_test.sv
// ----------------------------------------------------------------------------
// Assembler line token tagger testbench
// Streams source lines into the tagger one character word at a time: a short
// set of hand-made lines first, then random well-formed lines with random
// content, broken lines, raw byte noise and one long line of many arguments.
// Both sides idle in random bursts; the receiver also holds off long enough to
// back the tagger up. The checker beside the tagger predicts and compares.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module assembler_line_token_tagger_test;
  import altt_pkg::*;

  localparam int unsigned RANDOM_WORDS = 190;
  localparam int unsigned CALM_WORDS   = 40;
  localparam int unsigned LONG_CHARS   = 48;
  localparam int unsigned HOLD_CYCLES  = 150;
  localparam int unsigned QUIET_LIMIT  = 2000;
  localparam int unsigned SETTLE       = 8;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  in_t         in_word;
  logic        out_valid;
  logic        out_stall;
  out_t        out_word;
  int unsigned records_left;
  int unsigned fails;

  bit          idling_on;
  bit          hold_req;
  bit          hold_served;
  int unsigned words_sent;

  string name_chars  = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789_.$";
  string quote_fill  = "ab Z,;'\"\\x\t9";
  string label_words[6] = '{"equ", "EQU", "eQu", "equ:", "eq", "equal"};
  string op_words[9]    = '{"mov", "data", "DaTa", "dat", "datas", ".org", ".db", "ld", "jmp"};

  assembler_line_token_tagger u_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_word_i  (in_word),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_word_o (out_word)
  );

  assembler_line_token_tagger_check u_check (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_i (in_stall),
    .in_word_i  (in_word),
    .out_valid_i(out_valid),
    .out_stall_i(out_stall),
    .out_word_i (out_word),
    .pending_o  (records_left),
    .errors_o   (fails)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // ---- line builders ----

  function automatic void add_text(ref logic [7:0] t[$], input string s);
    for (int i = 0; i < s.len(); i++)
      t.insert(t.size(), s[i]);
  endfunction

  function automatic void add_blanks(ref logic [7:0] t[$], input int unsigned n);
    repeat (n) t.insert(t.size(), $urandom_range(0, 3) == 0 ? CH_TAB : CH_SPACE);
  endfunction

  function automatic void add_name(ref logic [7:0] t[$], input int unsigned n);
    repeat (n) t.insert(t.size(), name_chars[$urandom_range(0, name_chars.len() - 1)]);
  endfunction

  function automatic void add_quoted(ref logic [7:0] t[$]);
    logic [7:0] q;
    q = $urandom_range(0, 1) ? CH_DQUOTE : CH_SQUOTE;
    t.insert(t.size(), q);
    repeat ($urandom_range(0, 5)) begin
      if ($urandom_range(0, 4) == 0) begin
        t.insert(t.size(), CH_BSLASH);
        t.insert(t.size(), q);
      end else begin
        t.insert(t.size(), quote_fill[$urandom_range(0, quote_fill.len() - 1)]);
      end
    end
    // Now and then the quote is left open until end of line.
    if ($urandom_range(0, 9) != 0)
      t.insert(t.size(), q);
  endfunction

  function automatic void add_comment(ref logic [7:0] t[$]);
    add_blanks(t, $urandom_range(0, 2));
    t.insert(t.size(), CH_SEMI);
    repeat ($urandom_range(0, 8))
      t.insert(t.size(),
               $urandom_range(0, 5) == 0 ? CH_TAB : 8'($urandom_range(8'h20, 8'h7E)));
  endfunction

  function automatic void build_line(ref logic [7:0] t[$]);
    int unsigned n_args;
    case ($urandom_range(0, 5))
      0, 1: begin
        add_name(t, $urandom_range(1, 6));
        case ($urandom_range(0, 3))
          0: t.insert(t.size(), CH_COLON);
          1: t.insert(t.size(), CH_COMMA);
          default: ;
        endcase
        add_blanks(t, $urandom_range(1, 2));
      end
      2: begin
        add_text(t, label_words[$urandom_range(0, 5)]);
        add_blanks(t, $urandom_range(1, 2));
      end
      3: t.insert(t.size(), CH_NUL);
      default: add_blanks(t, $urandom_range(1, 3));
    endcase
    if ($urandom_range(0, 9) == 0) begin
      add_comment(t);
      return;
    end
    case ($urandom_range(0, 5))
      0: add_name(t, $urandom_range(1, 5));
      1: add_quoted(t);
      default: add_text(t, op_words[$urandom_range(0, 8)]);
    endcase
    if ($urandom_range(0, 4) != 0) begin
      add_blanks(t, $urandom_range(1, 2));
      n_args = $urandom_range(0, 5);
      for (int i = 0; i < n_args; i++) begin
        if (i > 0)
          t.insert(t.size(), CH_COMMA);
        add_blanks(t, $urandom_range(0, 3) == 0 ? 1 : 0);
        case ($urandom_range(0, 5))
          0: ;
          1: add_quoted(t);
          2: begin
            add_name(t, $urandom_range(1, 4));
            add_blanks(t, $urandom_range(1, 2));
          end
          default: add_name(t, $urandom_range(1, 4));
        endcase
      end
    end
    if ($urandom_range(0, 2) == 0)
      add_comment(t);
    if ($urandom_range(0, 3) == 0)
      add_blanks(t, $urandom_range(1, 3));
  endfunction

  // ---- driving ----

  task automatic push_word(input in_t w);
    if (idling_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Words without a character that do not end the line must change nothing.
  task automatic push_noise();
    in_t w;
    w.ch          = 8'($urandom_range(0, 255));
    w.has_char    = 1'b0;
    w.end_of_line = 1'b0;
    push_word(w);
  endtask

  task automatic send_line(input logic [7:0] t[$]);
    in_t w;
    bit  end_alone;
    end_alone = (t.size() == 0) || ($urandom_range(0, 2) == 0);
    foreach (t[i]) begin
      if ($urandom_range(0, 9) == 0)
        push_noise();
      w.ch          = t[i];
      w.has_char    = 1'b1;
      w.end_of_line = !end_alone && (i == t.size() - 1);
      push_word(w);
      words_sent++;
    end
    if (end_alone) begin
      w.ch          = 8'($urandom_range(0, 255));
      w.has_char    = 1'b0;
      w.end_of_line = 1'b1;
      push_word(w);
      words_sent++;
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (records_left != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // ---- receiver ----

  initial begin : receiver
    out_stall <= 1'b0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (hold_req && !hold_served) begin
        hold_served = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
      end else if (idling_on && $urandom_range(0, 4) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 7)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // ---- watchdog ----

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall))
        quiet = 0;
      else
        quiet++;
    end
    $display("assembler_line_token_tagger_test failed");
    $finish;
  end

  // ---- stimulus ----

  initial begin : stimulus
    logic [7:0]  line[$];
    int unsigned target;
    int unsigned first_random;
    bit          long_done;
    in_valid  <= 1'b0;
    in_word   <= '0;
    rst_n     <= 1'b0;
    idling_on  = 1'b1;
    hold_req   = 1'b0;
    long_done  = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Empty line gives only the summary.
    line.delete();
    send_line(line);
    push_noise();
    // Label equal to the keyword without a colon.
    line.delete();
    add_text(line, "equ");
    send_line(line);
    // NUL in column 0 starts the opcode; the comment holds only the semicolon.
    line.delete();
    line.insert(line.size(), CH_NUL);
    add_text(line, "d ;");
    send_line(line);
    // Label with a trimmed comma, an escaped quote whose swallowed character is
    // a comma, an empty argument, a trailing blank and too many arguments.
    line.delete();
    add_text(line, "L, op \"a\\\"\",,z ,w ");
    send_line(line);

    first_random = words_sent;
    target       = words_sent + RANDOM_WORDS;
    while (words_sent < target) begin
      idling_on = (words_sent + CALM_WORDS < target);
      line.delete();
      if (!long_done && words_sent > first_random + 60) begin
        // Long line of short arguments; the receiver holds off meanwhile so
        // the result queue fills and the input stalls.
        long_done = 1'b1;
        add_blanks(line, 1);
        add_text(line, $urandom_range(0, 1) ? "mov" : "data");
        add_blanks(line, 1);
        while (line.size() < LONG_CHARS) begin
          if ($urandom_range(0, 15) == 0)
            add_quoted(line);
          else
            add_name(line, $urandom_range(1, 2));
          if ($urandom_range(0, 7) == 0)
            add_blanks(line, 1);
          line.insert(line.size(), CH_COMMA);
        end
        hold_req = 1'b1;
        send_line(line);
        wait_drained();
      end else begin
        case ($urandom_range(0, 9))
          0: repeat ($urandom_range(0, 12)) line.insert(line.size(), 8'($urandom_range(0, 255)));
          1: begin
            build_line(line);
            while (line.size() > $urandom_range(0, 6)) void'(line.pop_back());
          end
          default: build_line(line);
        endcase
        send_line(line);
        if ($urandom_range(0, 19) == 0)
          wait_drained();
      end
    end

    wait_drained();
    if (fails == 0)
      $display("assembler_line_token_tagger_test passed");
    else
      $display("assembler_line_token_tagger_test failed");
    $finish;
  end

endmodule
